### hdl/cswq_pkg.sv
package cswq_pkg;

  // Depth of the queue of blocked requesters and width of a kept id.
  localparam int WAIT_DEPTH = 16;
  localparam int ID_BITS    = 8;

  localparam int PTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int FILL_W = $clog2(WAIT_DEPTH + 1);

  // Field widths fixed by the interface.
  localparam int KIND_W    = 1;
  localparam int PROC_ID_W = 8;
  localparam int INIT_W    = 9;
  localparam int COUNT_W   = 10;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX   = 10'sd511;
  localparam logic signed [COUNT_W-1:0] COUNT_RESET = 10'sd1;

  // Operation codes of the kind field.
  localparam logic [KIND_W-1:0] KIND_WAIT   = 1'b0;
  localparam logic [KIND_W-1:0] KIND_SIGNAL = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted item and read the queue head
    logic commit;  // apply the operation and load the result register
  } cswq_cmd_t;

endpackage

### hdl/cswq_ctrl.sv
module cswq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cswq_pkg::cswq_cmd_t cmd_o
);
  import cswq_pkg::*;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_EXEC = 1'b1;

  logic [0:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The result register can take a new result when it is empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_commit_sets_valid: assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd_o.commit |=> out_valid_q
  ) else $error("result not presented after commit");

  a_no_overwrite: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && out_stall_i) |-> !cmd_o.commit
  ) else $error("pending result overwritten");

  a_stalled_valid_held: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && out_stall_i) |=> out_valid_q
  ) else $error("stalled result dropped");
`endif

endmodule

### hdl/cswq_dp.sv
module cswq_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cswq_pkg::cswq_cmd_t                   cmd_i,
  input  logic                                  cfg_we_i,
  input  logic [cswq_pkg::INIT_W-1:0]           cfg_wdata_i,
  input  logic [cswq_pkg::KIND_W-1:0]           kind_i,
  input  logic [cswq_pkg::PROC_ID_W-1:0]        proc_id_i,
  output logic                                  granted_o,
  output logic                                  blocked_o,
  output logic                                  overflow_o,
  output logic                                  woke_valid_o,
  output logic [cswq_pkg::PROC_ID_W-1:0]        woke_id_o,
  output logic signed [cswq_pkg::COUNT_W-1:0]   count_now_o
);
  import cswq_pkg::*;

  logic [ID_BITS-1:0]        mem [WAIT_DEPTH];
  logic [ID_BITS-1:0]        rd_q;
  logic [KIND_W-1:0]         kind_q;
  logic [ID_BITS-1:0]        id_q;

  logic signed [COUNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0]          head_q, head_d, tail_q, tail_d;
  logic [FILL_W-1:0]         fill_q, fill_d;

  logic                      granted_q, granted_d;
  logic                      blocked_q, blocked_d;
  logic                      overflow_q, overflow_d;
  logic                      woke_valid_q, woke_valid_d;
  logic [PROC_ID_W-1:0]      woke_id_q, woke_id_d;
  logic signed [COUNT_W-1:0] count_now_q, count_now_d;

  logic                      push, pop;
  logic signed [COUNT_W-1:0] cnt_dec, cnt_inc;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(WAIT_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    cnt_dec = count_q - COUNT_W'(1);
    cnt_inc = (count_q < COUNT_MAX) ? count_q + COUNT_W'(1) : count_q;

    push         = 1'b0;
    pop          = 1'b0;
    granted_d    = 1'b0;
    blocked_d    = 1'b0;
    overflow_d   = 1'b0;
    woke_valid_d = 1'b0;
    woke_id_d    = '0;
    count_d      = count_q;

    if (kind_q == KIND_WAIT) begin
      if (fill_q == FILL_W'(WAIT_DEPTH)) begin
        overflow_d = 1'b1;
      end else begin
        count_d = cnt_dec;
        if (cnt_dec < 0) begin
          push      = 1'b1;
          blocked_d = 1'b1;
        end else begin
          granted_d = 1'b1;
        end
      end
    end else begin
      count_d = cnt_inc;
      if ((cnt_inc <= 0) && (fill_q != '0)) begin
        pop          = 1'b1;
        woke_valid_d = 1'b1;
        woke_id_d    = PROC_ID_W'(rd_q);
      end
    end
    count_now_d = count_d;

    head_d = pop  ? next_slot(head_q) : head_q;
    tail_d = push ? next_slot(tail_q) : tail_q;
    fill_d = fill_q;
    if (push) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (pop) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  // Semaphore state. A configuration write reloads the count and empties the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
    end else if (cfg_we_i) begin
      count_q <= $signed(COUNT_W'(cfg_wdata_i));
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
    end
  end

  // Queue storage, item capture and the result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      id_q   <= ID_BITS'(proc_id_i);
      rd_q   <= mem[head_q];
    end
    if (cmd_i.commit && push) begin
      mem[tail_q] <= id_q;
    end
    if (cmd_i.commit) begin
      granted_q    <= granted_d;
      blocked_q    <= blocked_d;
      overflow_q   <= overflow_d;
      woke_valid_q <= woke_valid_d;
      woke_id_q    <= woke_id_d;
      count_now_q  <= count_now_d;
    end
  end

  assign granted_o    = granted_q;
  assign blocked_o    = blocked_q;
  assign overflow_o   = overflow_q;
  assign woke_valid_o = woke_valid_q;
  assign woke_id_o    = woke_id_q;
  assign count_now_o  = count_now_q;

`ifndef SYNTH
  a_fill_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni) fill_q <= FILL_W'(WAIT_DEPTH)
  ) else $error("wait queue fill beyond depth");

  a_empty_when_nonneg: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (count_q >= 0) |-> (fill_q == '0)
  ) else $error("waiters queued while count is not negative");

  a_fill_matches_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (count_q < 0) |-> (COUNT_W'(fill_q) == COUNT_W'(-count_q))
  ) else $error("queue fill does not match negative count");
`endif

endmodule

### hdl/counting_semaphore_wait_queue_top.sv
// Flow: an accepted transaction is captured together with a registered read of the wait
// queue head, then committed in the update state once the result register is free.
// A new transaction is not taken until the current one is committed, since the input
// stalls while the update state is pending.
// Reset: the count is 1 and the wait queue is empty; queue entries are not cleared
// and no clearing pass is needed, so transactions are accepted right after reset.
module counting_semaphore_wait_queue_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [cswq_pkg::INIT_W-1:0]           cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [cswq_pkg::KIND_W-1:0]           kind_i,
  input  logic [cswq_pkg::PROC_ID_W-1:0]        proc_id_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  granted_o,
  output logic                                  blocked_o,
  output logic                                  overflow_o,
  output logic                                  woke_valid_o,
  output logic [cswq_pkg::PROC_ID_W-1:0]        woke_id_o,
  output logic signed [cswq_pkg::COUNT_W-1:0]   count_now_o
);
  import cswq_pkg::*;

  // The controller sequences each transaction through two steps: capture with a
  // read of the queue head, then the update of count and queue pointers. The
  // result lands in an output register, so the next input transaction is taken
  // while a finished result still waits for the downstream side.
  cswq_cmd_t cmd;

  cswq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // The datapath holds the count, the circular wait queue and the result register.
  // A configuration write reloads the count and empties the queue.
  cswq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .kind_i       (kind_i),
    .proc_id_i    (proc_id_i),
    .granted_o    (granted_o),
    .blocked_o    (blocked_o),
    .overflow_o   (overflow_o),
    .woke_valid_o (woke_valid_o),
    .woke_id_o    (woke_id_o),
    .count_now_o  (count_now_o)
  );

endmodule
